FILE: hdl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Operation and status codes, fixed field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int KIND_W     = 2;
  localparam int POS_W      = 10;
  localparam int FIELD_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 10;
  localparam int GROUP_SIZE = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2
  } status_e;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [POS_W-1:0] slot;
  } cell_ctrl_t;

endpackage

FILE: hdl/pal_req_if.sv
// ----------------------------------------------------------------------------
// pal_req_if: request channel of the positional array list
// Valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface pal_req_if
  import pal_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [POS_W-1:0]   position;
  logic [FIELD_W-1:0]        entry;

  modport source (output valid, kind, position, entry, input ready);
  modport sink   (input valid, kind, position, entry, output ready);
endinterface

FILE: hdl/pal_rsp_if.sv
// ----------------------------------------------------------------------------
// pal_rsp_if: response channel of the positional array list
// Valid/ready handshake carrying status, read data and fill count.
// ----------------------------------------------------------------------------
interface pal_rsp_if
  import pal_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [FIELD_W-1:0]    read_entry;
  logic [COUNT_W-1:0]    count;

  modport source (output valid, status, read_entry, count, input ready);
  modport sink   (input valid, status, read_entry, count, output ready);
endinterface

FILE: hdl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one storage cell of the list chain
// Holds the entry at a fixed position; shifts up, down or loads a new entry.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
#(
  parameter int ENTRY_W = 32,
  parameter int IDX_W   = 10,
  parameter int INDEX   = 0
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [ENTRY_W-1:0] ins_val_i,
  input  logic [ENTRY_W-1:0] left_i,
  input  logic [ENTRY_W-1:0] right_i,
  output logic [ENTRY_W-1:0] entry_o,
  output logic [ENTRY_W-1:0] hit_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ENTRY_W-1:0] entry_q, entry_d;
  logic [IDX_W-1:0]   slot;
  logic               above, at;

  assign slot  = IDX_W'(ctrl_i.slot);
  assign above = MyIdx > slot;
  assign at    = MyIdx == slot;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (above) begin
        entry_d = left_i;
      end else if (at) begin
        entry_d = ins_val_i;
      end
    end else if (ctrl_i.del && (above || at)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = (ctrl_i.rd && at) ? entry_q : '0;

endmodule

FILE: hdl/pal_read_tree.sv
// ----------------------------------------------------------------------------
// pal_read_tree: registered OR tree over the gated cell outputs
// Reduce groups into a register, then fold the groups into one word.
// ----------------------------------------------------------------------------
module pal_read_tree
  import pal_pkg::*;
#(
  parameter int ENTRY_W  = 32,
  parameter int CAPACITY = 512
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [ENTRY_W-1:0] hits_i [CAPACITY],
  output logic [ENTRY_W-1:0] word_o
);

  localparam int NumGroups = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [ENTRY_W-1:0] grp_q [NumGroups];
  logic [ENTRY_W-1:0] grp_d [NumGroups];

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | hits_i[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

FILE: hdl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: bounded ordered list held in a chain of cells
// Insert after a position, delete, read and clear, one result per request.
// ----------------------------------------------------------------------------
// Order: an accepted request passes the execute and reduce states; its
//   response then goes to the output register, reduce holding while it is full.
// The next request is taken while the last response still waits at the output,
//   but only once the last request has left reduce.
// Reset: asynchronous, active low; empties the list (count zero) and drops
//   any pending response. Cell contents are not cleared.
// ----------------------------------------------------------------------------
module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY    = 512,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pal_req_if.sink   req_i,
  pal_rsp_if.source rsp_o
);

  // Only the low field bits of an entry are ever kept
  localparam int ENT_W   = (ENTRY_WIDTH < FIELD_W) ? ENTRY_WIDTH : FIELD_W;
  localparam int OCC_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
  localparam int CMP_W   = (OCC_W > POS_W) ? OCC_W : POS_W;
  localparam logic [OCC_W-1:0] FullCount = OCC_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_e;

  state_e             state_q;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic               out_valid_q;
  logic               out_load;
  status_e            status_q, status_d;
  logic [COUNT_W-1:0] count_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FIELD_W-1:0] out_entry_q;
  logic [COUNT_W-1:0] out_count_q;

  // Request held for the execute step
  kind_e              kind_q;
  logic [POS_W-1:0]   pos_q;
  logic [ENT_W-1:0]   val_q;

  cell_ctrl_t         ctrl;
  logic [ENT_W-1:0]   cell_q   [CAPACITY];
  logic [ENT_W-1:0]   cell_hit [CAPACITY];
  logic [ENT_W-1:0]   read_word;

  logic               pos_ok, pos_front, list_full;
  logic [CMP_W-1:0]   occ_ext_d;

  // --------------------------------------------------------------------------
  // Execute step: check the request against the current fill and drive the
  // whole chain from it. A position is valid when it is non-negative and
  // below the fill; inserting takes -1 as "at the front".
  // --------------------------------------------------------------------------
  always_comb begin
    pos_front = pos_q == '1;
    pos_ok    = !pos_q[POS_W-1] && (CMP_W'(pos_q) < CMP_W'(occ_q));
    list_full = occ_q == FullCount;
    occ_d     = occ_q;
    status_d  = STATUS_OK;
    ctrl      = '0;
    ctrl.slot = pos_q;
    if (state_q == S_EXEC) begin
      unique case (kind_q)
        KIND_INSERT: begin
          if (list_full) begin
            status_d = STATUS_FULL;
          end else if (!pos_front && !pos_ok) begin
            status_d = STATUS_BADPOS;
          end else begin
            ctrl.ins  = 1'b1;
            ctrl.slot = pos_front ? '0 : pos_q + POS_W'(1);
            occ_d     = occ_q + OCC_W'(1);
          end
        end
        KIND_DELETE: begin
          if (!pos_ok) begin
            status_d = STATUS_BADPOS;
          end else begin
            ctrl.del = 1'b1;
            occ_d    = occ_q - OCC_W'(1);
          end
        end
        KIND_READ: begin
          if (!pos_ok) begin
            status_d = STATUS_BADPOS;
          end else begin
            ctrl.rd = 1'b1;
          end
        end
        KIND_CLEAR: begin
          occ_d = '0;
        end
        default: begin
          status_d = STATUS_OK;
        end
      endcase
    end
  end

  assign occ_ext_d = CMP_W'(occ_d);

  // --------------------------------------------------------------------------
  // Chain of cells: each cell above the insert slot takes its left neighbour, each
  // at or above the delete slot its right. The last cell sees itself past the edge.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENT_W-1:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_val = val_q;
    end else begin : g_mid_l
      assign left_val = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_q[i];
    end else begin : g_mid_r
      assign right_val = cell_q[i+1];
    end
    pal_cell #(
      .ENTRY_W (ENT_W),
      .IDX_W   (IDX_W),
      .INDEX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .ins_val_i (val_q),
      .left_i    (left_val),
      .right_i   (right_val),
      .entry_o   (cell_q[i]),
      .hit_o     (cell_hit[i])
    );
  end

  // Read data: only the addressed cell can drive a non-zero word
  pal_read_tree #(
    .ENTRY_W  (ENT_W),
    .CAPACITY (CAPACITY)
  ) u_read_tree (
    .clk_i  (clk_i),
    .en_i   (state_q == S_EXEC),
    .hits_i (cell_hit),
    .word_o (read_word)
  );

  // --------------------------------------------------------------------------
  // Control: idle -> execute -> reduce, then hand the result to the output
  // register as soon as it is free. Hold in reduce while it is not.
  // --------------------------------------------------------------------------
  assign out_load = (state_q == S_REDUCE) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      count_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          occ_q    <= occ_d;
          status_q <= status_d;
          count_q  <= occ_ext_d[COUNT_W-1:0];
          state_q  <= S_REDUCE;
        end
        S_REDUCE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      kind_q <= kind_e'(req_i.kind);
      pos_q  <= req_i.position;
      val_q  <= req_i.entry[ENT_W-1:0];
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_entry_q  <= FIELD_W'(read_word);
      out_count_q  <= count_q;
    end
  end

  assign req_i.ready      = state_q == S_IDLE;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_entry = out_entry_q;
  assign rsp_o.count      = out_count_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullCount)
    else $error("fill count beyond capacity");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && kind_q == KIND_INSERT && list_full)
      |=> (status_q == STATUS_FULL && $stable(occ_q)))
    else $error("insert into full list not refused");

  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != STATUS_OK) |-> rsp_o.read_entry == '0)
    else $error("read data on a failed request");

  a_single_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && kind_q != KIND_CLEAR)
      |=> (occ_q == $past(occ_q) || occ_q == $past(occ_q) + OCC_W'(1)
           || occ_q == $past(occ_q) - OCC_W'(1)))
    else $error("fill count moved by more than one");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional array list
// Drives insert, delete, read and clear requests through the request channel,
// keeps a shadow copy of the list to predict every response, and compares
// each response field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pal_pkg::*;

  localparam int CAPACITY    = 512;
  localparam int ENTRY_WIDTH = 32;
  localparam int MAX_GAP     = 15;
  localparam int HOLD_OFF    = 200;   // long receiver stall in the backpressure test
  localparam int DRAIN_WAIT  = 20;    // final wait for any stray response
  localparam int CYCLE_LIMIT = 600_000;

  // One predicted response
  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] read_entry;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  pal_req_if req ();
  pal_rsp_if rsp ();

  positional_array_list #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shadow of the list contents and fill level
  logic [FIELD_W-1:0] shadow_entries [CAPACITY];
  int                 shadow_fill = 0;

  // Responses still owed by the block, oldest first
  list_result_t pending_results [$];

  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;   // random gaps on both channels
  int          hold_cycles = 0;      // one-off receiver stall, consumed by the checker
  int unsigned next_gap    = 0;      // sender gap before the next request
  bit          offering    = 1'b0;   // mirrors req.valid as last driven

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort the run if it hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow list and return the response.
  // A position is valid when it lies in 0 .. fill-1; insert also takes -1 for
  // the front, and a full list is reported before any position check.
  // --------------------------------------------------------------------------
  function automatic list_result_t apply_list_op(kind_e op,
                                                 logic signed [POS_W-1:0] pos,
                                                 logic [FIELD_W-1:0] value);
    list_result_t res;
    int           p;
    bit           in_range;
    res.status     = STATUS_OK;
    res.read_entry = '0;
    p              = pos;             // sign-extends
    in_range       = (p >= 0) && (p < shadow_fill);
    case (op)
      KIND_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else if (p != -1 && !in_range) begin
          res.status = STATUS_BADPOS;
        end else begin
          // shift the tail up and drop the entry in after the position
          for (int i = shadow_fill; i > p + 1; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p+1] = value;
          shadow_fill++;
        end
      end
      KIND_DELETE: begin
        if (!in_range) begin
          res.status = STATUS_BADPOS;
        end else begin
          for (int i = p; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      KIND_READ: begin
        if (!in_range) res.status = STATUS_BADPOS;
        else           res.read_entry = shadow_entries[p];
      end
      default: begin
        shadow_fill = 0;
      end
    endcase
    res.count = shadow_fill[COUNT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Lower valid, at most once per time step
  task automatic drop_request();
    if (offering) begin
      req.valid <= 1'b0;
      offering   = 1'b0;
    end
  endtask

  // Offer one request, wait for the handshake and record its response.
  // Valid stays high into the next request when no gap follows.
  task automatic send_request(kind_e op, logic signed [POS_W-1:0] pos,
                              logic [FIELD_W-1:0] value);
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    req.kind     <= op;
    req.position <= pos;
    req.entry    <= value;
    if (!offering) begin
      req.valid <= 1'b1;
      offering   = 1'b1;
    end
    // inputs only move at rising edges, so the falling edge sees settled values
    do @(negedge clk_i); while (req.ready !== 1'b1);
    pending_results.push_back(apply_list_op(op, pos, value));
    @(posedge clk_i);
    next_gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (next_gap > 0) drop_request();
  endtask

  // Pause the sender until every owed response has come back
  task automatic wait_all_results();
    drop_request();
    next_gap = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Response side: take responses with random stalls and check each one
  // --------------------------------------------------------------------------
  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      $error("response with nothing owed: status %0d read_entry %h count %0d",
             rsp.status, rsp.read_entry, rsp.count);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (rsp.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, rsp.status);
        error_count++;
      end
      if (rsp.read_entry !== want.read_entry) begin
        $error("read_entry: expected %h, got %h", want.read_entry, rsp.read_entry);
        error_count++;
      end
      if (rsp.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, rsp.count);
        error_count++;
      end
    end
  endtask

  initial begin : response_checker
    int unsigned stall;
    rsp.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    rsp.ready <= 1'b1;
    forever begin
      do @(negedge clk_i); while (rsp.valid !== 1'b1);
      check_result();
      @(posedge clk_i);
      // draw the stall before the next response, plus any long hold-off asked for
      stall       = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      stall      += hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        rsp.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, every operation and the bad-position cases on a short list
  task automatic test_directed();
    send_request(KIND_READ,   0,  32'h1234_5678);   // empty list: nothing to read
    send_request(KIND_DELETE, 0,  '0);
    send_request(KIND_INSERT, 0,  32'hDEAD_BEEF);   // empty list takes only the front
    send_request(KIND_INSERT, -1, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 0,  32'h0000_0000);
    send_request(KIND_INSERT, -1, 32'hA5A5_5A5A);
    send_request(KIND_INSERT, 2,  32'h0000_0001);   // append after the last entry
    send_request(KIND_READ,   0,  '0);
    send_request(KIND_READ,   1,  32'hFFFF_FFFF);
    send_request(KIND_READ,   2,  '0);
    send_request(KIND_READ,   3,  '0);
    send_request(KIND_READ,   4,  '0);              // one past the end
    send_request(KIND_READ,   511, '0);             // largest position
    send_request(KIND_READ,   -1, '0);              // front marker is insert only
    send_request(KIND_DELETE, -512, '0);            // most negative position
    send_request(KIND_INSERT, -2, 32'h5555_AAAA);
    send_request(KIND_INSERT, 4,  32'h5555_AAAA);
    send_request(KIND_DELETE, 3,  '0);
    send_request(KIND_DELETE, 0,  32'hFFFF_FFFF);
    send_request(KIND_READ,   0,  '0);
    send_request(KIND_CLEAR,  511, 32'hFFFF_FFFF);
    send_request(KIND_READ,   0,  '0);
    send_request(KIND_CLEAR,  -1, '0);              // clear an empty list
    send_request(KIND_INSERT, -1, 32'h8000_0000);
  endtask

  // Fill the list to capacity, hit the full case, then work at the far end
  task automatic test_fill_to_capacity();
    send_request(KIND_CLEAR, 0, '0);
    idle_on = 1'b0;                                 // a stretch with no idling
    while (shadow_fill < CAPACITY)
      send_request(KIND_INSERT, $urandom_range(0, shadow_fill) - 1, $urandom());
    idle_on = 1'b1;
    send_request(KIND_INSERT, -1,  32'h1111_1111);
    send_request(KIND_INSERT, -2,  32'h2222_2222);  // full reported before position
    send_request(KIND_INSERT, 511, 32'h3333_3333);
    send_request(KIND_READ,   511, '0);
    send_request(KIND_READ,   0,   '0);
    send_request(KIND_DELETE, 511, '0);
    send_request(KIND_READ,   511, '0);
    send_request(KIND_INSERT, 510, 32'hFFFF_FFFF);
    send_request(KIND_DELETE, 0,   '0);
    send_request(KIND_INSERT, -1,  32'h0000_0000);
    for (int i = 0; i < 12; i++)
      send_request(KIND_READ, $urandom_range(0, CAPACITY - 1), $urandom());
    send_request(KIND_DELETE, 300, '0);
    send_request(KIND_INSERT, 299, $urandom());
    send_request(KIND_CLEAR,  0,   '0);
  endtask

  // Stall the receiver for a long stretch while requests keep coming, then
  // hold the sender back until the block has drained
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = HOLD_OFF;
    for (int i = 0; i < 40; i++) begin
      if (shadow_fill == 0 || i % 3 != 2)
        send_request(KIND_INSERT, $urandom_range(0, shadow_fill) - 1, $urandom());
      else
        send_request(KIND_READ, $urandom_range(0, shadow_fill - 1), $urandom());
    end
    wait_all_results();
    idle_on = 1'b1;
  endtask

  // One random request; most are well formed against the shadow fill level
  task automatic random_request(int unsigned insert_pct);
    int unsigned             roll;
    kind_e                   op;
    logic signed [POS_W-1:0] pos;
    logic [FIELD_W-1:0]      value;
    roll  = $urandom_range(0, 999);
    value = $urandom();
    if (roll < 5) begin
      op  = KIND_CLEAR;
      pos = $urandom_range(0, 1023);
    end else if (roll < 60) begin
      // noise: any operation at any position
      op  = kind_e'($urandom_range(0, 3));
      pos = $urandom_range(0, 1023);
    end else if (shadow_fill == 0 || $urandom_range(0, 99) < insert_pct) begin
      op  = KIND_INSERT;
      pos = $urandom_range(0, shadow_fill) - 1;
    end else begin
      op  = $urandom_range(0, 1) ? KIND_DELETE : KIND_READ;
      pos = $urandom_range(0, shadow_fill - 1);
    end
    send_request(op, pos, value);
  endtask

  // Phases that grow the list and shrink it again, some without idling
  task automatic test_random();
    int unsigned insert_bias [8] = '{80, 80, 80, 50, 20, 20, 60, 50};
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 2);
      for (int i = 0; i < 168; i++) random_request(insert_bias[ph]);
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    req.valid    <= 1'b0;
    req.kind     <= KIND_READ;
    req.position <= '0;
    req.entry    <= '0;
    rst_ni       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_capacity();
    test_backpressure();
    test_random();

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d responses never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
